>>> src/rsm_pkg.sv
// Shared constants and widths for the row softmax block.
package rsm_pkg;

	localparam int MAX_CLASSES_DEF = 16;

	localparam int LOGIT_W = 16;
	localparam int PROB_W  = 16;
	localparam int IDX_W   = 4;
	localparam int EXP_W   = 17;
	localparam int SUM_W   = 32;
	localparam int SHIFT_W = 5;

	localparam logic [15:0] LOG2E_Q8   = 16'd369;
	localparam logic [15:0] POLY_C1    = 16'd43024;
	localparam logic [15:0] POLY_C2    = 16'd10256;
	localparam logic [15:0] EXP_CUTOFF = 16'd4096;
	localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 5'd17;

	localparam logic [LOGIT_W-1:0] MAX_RESET = 16'h8000;
	localparam logic [PROB_W-1:0]  PROB_SAT  = 16'hFFFF;

endpackage

>>> src/rsm_row_mem.sv
// Row logit storage: one write port, one registered read port.
module rsm_row_mem #(
	parameter int DEPTH = rsm_pkg::MAX_CLASSES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [rsm_pkg::LOGIT_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [rsm_pkg::LOGIT_W-1:0] rd_data
);
	import rsm_pkg::*;

	logic [LOGIT_W-1:0] mem_q [DEPTH];
	logic [LOGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/rsm_exp_unit.sv
// exp(-a) in Q1.16 through one shared 16x16 multiplier over four steps.
module rsm_exp_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [15:0]               arg,
	output logic                      done,
	output logic [rsm_pkg::EXP_W-1:0] value
);
	import rsm_pkg::*;

	localparam logic [2:0] STEP_T  = 3'd1;
	localparam logic [2:0] STEP_U2 = 3'd2;
	localparam logic [2:0] STEP_C1 = 3'd3;
	localparam logic [2:0] STEP_C2 = 3'd4;

	logic               busy_q;
	logic [2:0]         step_q;
	logic               done_q;
	logic [15:0]        a_q;
	logic [15:0]        u_q;
	logic [15:0]        u2_q;
	logic [15:0]        c1u_q;
	logic [SHIFT_W-1:0] k_q;
	logic               kill_q;
	logic [EXP_W-1:0]   e_q;

	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] prod;
	logic [17:0] poly;
	logic [EXP_W-1:0] poly_sh;

	always_comb begin
		case (step_q)
			STEP_T: begin
				mul_a = a_q;
				mul_b = LOG2E_Q8;
			end
			STEP_U2: begin
				mul_a = u_q;
				mul_b = u_q;
			end
			STEP_C1: begin
				mul_a = POLY_C1;
				mul_b = u_q;
			end
			STEP_C2: begin
				mul_a = POLY_C2;
				mul_b = u2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign poly    = 18'h10000 + {2'b00, prod[31:16]} - {2'b00, c1u_q};
	assign poly_sh = poly[EXP_W-1:0] >> k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					step_q <= STEP_T;
				end
			end else if (step_q == STEP_C2) begin
				busy_q <= 1'b0;
				step_q <= '0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			a_q <= arg;
		end
		if (busy_q) begin
			case (step_q)
				STEP_T: begin
					u_q    <= prod[15:0];
					k_q    <= prod[20:16];
					kill_q <= (a_q > EXP_CUTOFF) || (prod[31:16] >= {11'd0, SHIFT_LIMIT});
				end
				STEP_U2: u2_q  <= prod[31:16];
				STEP_C1: c1u_q <= prod[31:16];
				STEP_C2: e_q   <= kill_q ? '0 : poly_sh;
				default: ;
			endcase
		end
	end

	assign done  = done_q;
	assign value = e_q;

endmodule

>>> src/rsm_div_unit.sv
// Restoring divider: (e << 16) / sum, one quotient bit per cycle, saturated.
module rsm_div_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rsm_pkg::EXP_W-1:0]  dividend,
	input  logic [rsm_pkg::SUM_W-1:0]  divisor,
	output logic                       done,
	output logic [rsm_pkg::PROB_W-1:0] quotient
);
	import rsm_pkg::*;

	localparam int REM_W = SUM_W + 2;
	localparam logic [4:0] LAST_BIT = 5'(EXP_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [REM_W-1:0]   rem_q;
	logic [EXP_W-1:0]   q_q;
	logic [SUM_W-1:0]   div_q;

	logic [REM_W-1:0] trial;
	logic             fits;

	assign trial = (cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign fits  = trial >= {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (cnt_q == LAST_BIT) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			rem_q <= {{(REM_W-EXP_W){1'b0}}, dividend};
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {2'b00, div_q}) : trial;
			q_q   <= {q_q[EXP_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = q_q[EXP_W-1] ? PROB_SAT : q_q[PROB_W-1:0];

endmodule

>>> src/row_softmax_top.sv
// Row softmax top level: row capture, max, exp sum pass and divide pass.
//
//  channel | beat fields                           | handshake
//  in      | logit[15:0] signed, last               | logit_valid / logit_ready
//  out     | probability[15:0], class_index, final_res | prob_valid / prob_ready
//
// Logit beats are accepted back to back while a row is collected. After the last
// beat, the sum pass reads each logit and runs the four multiplier steps of the
// exp unit, and the output pass reads each logit again and runs the exp unit,
// the divider and the emit, where it waits while the output is stalled.
// logit_ready is low from the last beat until the final result is taken.
// Reset clears the row count, sum and sequencer and sets the maximum to the most negative logit.
module row_softmax_top #(
	parameter int MAX_CLASSES = rsm_pkg::MAX_CLASSES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        logit_valid,
	output logic                        logit_ready,
	input  logic [rsm_pkg::LOGIT_W-1:0] logit,
	input  logic                        last,
	output logic                        prob_valid,
	input  logic                        prob_ready,
	output logic [rsm_pkg::PROB_W-1:0]  probability,
	output logic [rsm_pkg::IDX_W-1:0]   class_index,
	output logic                        final_res
);
	import rsm_pkg::*;

	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLASSES);

	localparam logic [2:0] ST_COLLECT  = 3'd0;
	localparam logic [2:0] ST_READ     = 3'd1;
	localparam logic [2:0] ST_EXP_GO   = 3'd2;
	localparam logic [2:0] ST_EXP_WAIT = 3'd3;
	localparam logic [2:0] ST_DIV_WAIT = 3'd4;
	localparam logic [2:0] ST_EMIT     = 3'd5;

	logic [2:0]         state_q;
	logic               pass_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [LOGIT_W-1:0] max_q;
	logic [SUM_W-1:0]   sum_q;
	logic               out_valid_q;
	logic [PROB_W-1:0]  prob_q;
	logic [IDX_W-1:0]   class_q;
	logic               final_q;

	logic               in_acc;
	logic               out_acc;
	logic               store_ok;
	logic               is_last_idx;
	logic [LOGIT_W-1:0] rd_data;
	logic [16:0]        diff;
	logic               exp_done;
	logic [EXP_W-1:0]   exp_val;
	logic               div_done;
	logic [PROB_W-1:0]  div_q;
	logic [IDX_W+CW-1:0] idx_ext;

	assign in_acc      = logit_valid && logit_ready;
	assign out_acc     = prob_valid && prob_ready;
	assign store_ok    = count_q < MAX_CNT;
	assign is_last_idx = (idx_q + CW'(1)) == count_q;
	assign diff        = {max_q[15], max_q} - {rd_data[15], rd_data};
	assign idx_ext     = {{IDX_W{1'b0}}, idx_q};

	rsm_row_mem #(
		.DEPTH(MAX_CLASSES),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (in_acc && store_ok),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(logit),
		.rd_en  (state_q == ST_READ),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	rsm_exp_unit u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_EXP_GO),
		.arg   (diff[15:0]),
		.done  (exp_done),
		.value (exp_val)
	);

	rsm_div_unit u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_EXP_WAIT && exp_done && pass_q),
		.dividend(exp_val),
		.divisor (sum_q),
		.done    (div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			pass_q      <= 1'b0;
			count_q     <= '0;
			idx_q       <= '0;
			max_q       <= MAX_RESET;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						if (store_ok) begin
							count_q <= count_q + CW'(1);
							if ($signed(logit) > $signed(max_q)) begin
								max_q <= logit;
							end
						end
						if (last) begin
							idx_q   <= '0;
							pass_q  <= 1'b0;
							sum_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_EXP_GO;
				ST_EXP_GO: state_q <= ST_EXP_WAIT;
				ST_EXP_WAIT: begin
					if (exp_done) begin
						if (pass_q) begin
							state_q <= ST_DIV_WAIT;
						end else begin
							sum_q   <= sum_q + {{(SUM_W-EXP_W){1'b0}}, exp_val};
							state_q <= ST_READ;
							if (is_last_idx) begin
								idx_q  <= '0;
								pass_q <= 1'b1;
							end else begin
								idx_q <= idx_q + CW'(1);
							end
						end
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (is_last_idx) begin
							count_q <= '0;
							max_q   <= MAX_RESET;
							sum_q   <= '0;
							pass_q  <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_COLLECT;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_WAIT && div_done) begin
			prob_q  <= div_q;
			class_q <= idx_ext[IDX_W-1:0];
			final_q <= is_last_idx;
		end
	end

	assign logit_ready = (state_q == ST_COLLECT);
	assign prob_valid  = out_valid_q;
	assign probability = prob_q;
	assign class_index = class_q;
	assign final_res   = final_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(logit_ready && prob_valid))
		else $error("input taken while a result is pending");

	a_exp_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		exp_done |-> (state_q == ST_EXP_WAIT))
		else $error("exp result arrived outside its wait state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divide result arrived outside its wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("row count beyond capacity");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> (idx_q < count_q))
		else $error("row index beyond stored logits");

endmodule
